// ===== hw/rtl/rgpc_pkg.sv =====
// shared constants and types for the range gap penalty counter
`timescale 1ns / 1ps

package rgpc_pkg;

   localparam int ROW_W               = 64;
   localparam int CFG_W               = 7;
   localparam int GAP_W               = 11;
   localparam int PEN_W               = 17;
   localparam int GROUP_SIZE          = 8;
   localparam int GROUP_SUM_W         = GAP_W + $clog2(GROUP_SIZE);
   localparam int DEFAULT_MAX_COLUMNS = 64;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAP_W-1:0] GAP_LIMIT      = 11'd2047;
   localparam logic [PEN_W-1:0] PENALTY_LIMIT  = 17'd65536;
   localparam logic [CFG_W-1:0] COLUMNS_RESET  = 7'd64;

   localparam logic REG_COLUMNS_IN_USE = 1'b0;

   typedef struct packed {
      logic valid;
      logic last;
      logic sat;
   } ctl_type;

endpackage

// ===== hw/rtl/rgpc_req_if.sv =====
// row channel: valid/ready with one presence row per item
`timescale 1ns / 1ps

interface rgpc_req_if;
   logic                       valid;
   logic                       ready;
   logic [rgpc_pkg::ROW_W-1:0] presence_row;
   logic                       last_row;

   modport source (output valid, output presence_row, output last_row, input ready);
   modport sink (input valid, input presence_row, input last_row, output ready);
endinterface

// ===== hw/rtl/rgpc_rsp_if.sv =====
// result channel: valid/ready with penalty and saturation flag
`timescale 1ns / 1ps

interface rgpc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rgpc_pkg::PEN_W-1:0] penalty;
   logic                       saturated;

   modport source (output valid, output penalty, output saturated, input ready);
   modport sink (input valid, input penalty, input saturated, output ready);
endinterface

// ===== hw/rtl/rgpc_csr.sv =====
// apb register file holding the scored column count
`timescale 1ns / 1ps

module rgpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rgpc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rgpc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rgpc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [rgpc_pkg::CFG_W-1:0]          columns_in_use
);

   logic [rgpc_pkg::CFG_W-1:0] columns_ff;
   logic [rgpc_pkg::CFG_W-1:0] columns_in;
   logic                       write_hit;

   assign pready    = 1'b1;
   assign write_hit = psel && penable && pwrite && (paddr[2] == rgpc_pkg::REG_COLUMNS_IN_USE);

   always_comb begin
      columns_in = columns_ff;
      if (write_hit) begin
         columns_in = pwdata[rgpc_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= rgpc_pkg::COLUMNS_RESET;
      end else begin
         columns_ff <= columns_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         rgpc_pkg::REG_COLUMNS_IN_USE: begin
            prdata = {{(rgpc_pkg::CSR_DATA_W - rgpc_pkg::CFG_W){1'b0}}, columns_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign columns_in_use = columns_ff;

endmodule

// ===== hw/rtl/rgpc_column_bank.sv =====
// per-column seen flags and gap counters, registered gap contributions
`timescale 1ns / 1ps

module rgpc_column_bank #(
   parameter int MAX_COLUMNS = rgpc_pkg::DEFAULT_MAX_COLUMNS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic [rgpc_pkg::ROW_W-1:0]      presence_row,
   input  logic                            last_row,
   input  logic [rgpc_pkg::CFG_W-1:0]      columns_in_use,
   output rgpc_pkg::ctl_type               ctl_out,
   output logic [rgpc_pkg::GAP_W-1:0]      contrib [MAX_COLUMNS]
);

   localparam logic [rgpc_pkg::CFG_W-1:0] MAX_COLS_CFG = rgpc_pkg::CFG_W'(MAX_COLUMNS);

   logic                        seen_ff    [MAX_COLUMNS];
   logic                        seen_in    [MAX_COLUMNS];
   logic [rgpc_pkg::GAP_W-1:0]  gaps_ff    [MAX_COLUMNS];
   logic [rgpc_pkg::GAP_W-1:0]  gaps_in    [MAX_COLUMNS];
   logic [rgpc_pkg::GAP_W-1:0]  contrib_ff [MAX_COLUMNS];
   logic [rgpc_pkg::GAP_W-1:0]  contrib_in [MAX_COLUMNS];
   rgpc_pkg::ctl_type           ctl_ff;
   rgpc_pkg::ctl_type           ctl_in;
   logic [rgpc_pkg::CFG_W-1:0]  scored_cols;
   logic                        take;

   assign take        = advance && in_valid;
   assign scored_cols = (columns_in_use > MAX_COLS_CFG) ? MAX_COLS_CFG : columns_in_use;

   always_comb begin
      logic gap_sat;
      logic scored;
      logic present;
      gap_sat = 1'b0;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         scored        = rgpc_pkg::CFG_W'(c) < scored_cols;
         present       = presence_row[c];
         seen_in[c]    = seen_ff[c];
         gaps_in[c]    = gaps_ff[c];
         contrib_in[c] = '0;
         if (scored) begin
            if (present) begin
               if (seen_ff[c]) begin
                  contrib_in[c] = gaps_ff[c];
               end
               seen_in[c] = 1'b1;
               gaps_in[c] = '0;
            end else if (seen_ff[c]) begin
               if (gaps_ff[c] >= rgpc_pkg::GAP_LIMIT) begin
                  gap_sat = 1'b1;
               end else begin
                  gaps_in[c] = gaps_ff[c] + 1'b1;
               end
            end
         end
         if (!take) begin
            seen_in[c] = seen_ff[c];
            gaps_in[c] = gaps_ff[c];
         end else if (last_row) begin
            seen_in[c] = 1'b0;
            gaps_in[c] = '0;
         end
      end
      ctl_in.valid = in_valid;
      ctl_in.last  = last_row;
      ctl_in.sat   = gap_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_COLUMNS; c++) begin
            seen_ff[c] <= 1'b0;
            gaps_ff[c] <= '0;
         end
         ctl_ff.valid <= 1'b0;
      end else begin
         for (int c = 0; c < MAX_COLUMNS; c++) begin
            seen_ff[c] <= seen_in[c];
            gaps_ff[c] <= gaps_in[c];
         end
         if (advance) begin
            ctl_ff.valid <= ctl_in.valid;
         end
      end
      if (advance) begin
         ctl_ff.last <= ctl_in.last;
         ctl_ff.sat  <= ctl_in.sat;
         for (int c = 0; c < MAX_COLUMNS; c++) begin
            contrib_ff[c] <= contrib_in[c];
         end
      end
   end

   assign ctl_out = ctl_ff;
   assign contrib = contrib_ff;

endmodule

// ===== hw/rtl/rgpc_sum_tree.sv =====
// two-level registered adder tree over the column contributions
`timescale 1ns / 1ps

module rgpc_sum_tree #(
   parameter int MAX_COLUMNS = rgpc_pkg::DEFAULT_MAX_COLUMNS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  rgpc_pkg::ctl_type               ctl_in,
   input  logic [rgpc_pkg::GAP_W-1:0]      contrib [MAX_COLUMNS],
   output rgpc_pkg::ctl_type               ctl_out,
   output logic [rgpc_pkg::PEN_W-1:0]      row_sum
);

   localparam int GROUPS = (MAX_COLUMNS + rgpc_pkg::GROUP_SIZE - 1) / rgpc_pkg::GROUP_SIZE;

   logic [rgpc_pkg::GROUP_SUM_W-1:0] group_ff [GROUPS];
   logic [rgpc_pkg::GROUP_SUM_W-1:0] group_in [GROUPS];
   rgpc_pkg::ctl_type                mid_ctl_ff;
   rgpc_pkg::ctl_type                out_ctl_ff;
   logic [rgpc_pkg::PEN_W-1:0]       sum_ff;
   logic [rgpc_pkg::PEN_W-1:0]       sum_in;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < rgpc_pkg::GROUP_SIZE; k++) begin
            if (g * rgpc_pkg::GROUP_SIZE + k < MAX_COLUMNS) begin
               group_in[g] = group_in[g]
                  + rgpc_pkg::GROUP_SUM_W'(contrib[g * rgpc_pkg::GROUP_SIZE + k]);
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sum_in = sum_in + rgpc_pkg::PEN_W'(group_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ctl_ff.valid <= 1'b0;
         out_ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         mid_ctl_ff.valid <= ctl_in.valid;
         out_ctl_ff.valid <= mid_ctl_ff.valid;
      end
      if (advance) begin
         mid_ctl_ff.last <= ctl_in.last;
         mid_ctl_ff.sat  <= ctl_in.sat;
         out_ctl_ff.last <= mid_ctl_ff.last;
         out_ctl_ff.sat  <= mid_ctl_ff.sat;
         group_ff        <= group_in;
         sum_ff          <= sum_in;
      end
   end

   assign ctl_out = out_ctl_ff;
   assign row_sum = sum_ff;

endmodule

// ===== hw/rtl/rgpc_accum.sv =====
// clamped penalty accumulator and result registers
`timescale 1ns / 1ps

module rgpc_accum (
   input  logic                            clock,
   input  logic                            reset,
   input  rgpc_pkg::ctl_type               ctl_in,
   input  logic [rgpc_pkg::PEN_W-1:0]      row_sum,
   output logic                            advance,
   rgpc_rsp_if.source                      rsp_bus
);

   logic [rgpc_pkg::PEN_W-1:0] acc_ff;
   logic [rgpc_pkg::PEN_W-1:0] acc_in;
   logic                       acc_sat_ff;
   logic                       acc_sat_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [rgpc_pkg::PEN_W-1:0] rsp_penalty_ff;
   logic                       rsp_sat_ff;
   logic                       spare_valid_ff;
   logic                       spare_valid_in;
   logic [rgpc_pkg::PEN_W-1:0] spare_penalty_ff;
   logic                       spare_sat_ff;
   logic [rgpc_pkg::PEN_W:0]   total;
   logic                       over;
   logic [rgpc_pkg::PEN_W-1:0] clamped;
   logic                       sat_next;
   logic                       step;
   logic                       load_result;
   logic                       head_free;
   logic                       load_head;
   logic                       load_spare;

   // spare result slot keeps rsp ready off the input side
   assign advance     = !(ctl_in.valid && ctl_in.last && spare_valid_ff);
   assign step        = advance && ctl_in.valid;
   assign load_result = step && ctl_in.last;
   assign head_free   = !rsp_valid_ff || rsp_bus.ready;

   assign total    = {1'b0, acc_ff} + {1'b0, row_sum};
   assign over     = total > {1'b0, rgpc_pkg::PENALTY_LIMIT};
   assign clamped  = over ? rgpc_pkg::PENALTY_LIMIT : total[rgpc_pkg::PEN_W-1:0];
   assign sat_next = acc_sat_ff || ctl_in.sat || over;

   always_comb begin
      acc_in     = acc_ff;
      acc_sat_in = acc_sat_ff;
      if (step) begin
         if (ctl_in.last) begin
            acc_in     = '0;
            acc_sat_in = 1'b0;
         end else begin
            acc_in     = clamped;
            acc_sat_in = sat_next;
         end
      end
      rsp_valid_in   = rsp_valid_ff;
      spare_valid_in = spare_valid_ff;
      load_head      = 1'b0;
      load_spare     = 1'b0;
      if (head_free) begin
         rsp_valid_in   = spare_valid_ff || load_result;
         spare_valid_in = 1'b0;
         load_head      = spare_valid_ff || load_result;
      end else if (load_result) begin
         spare_valid_in = 1'b1;
         load_spare     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         acc_sat_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         acc_ff         <= acc_in;
         acc_sat_ff     <= acc_sat_in;
         rsp_valid_ff   <= rsp_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_head) begin
         rsp_penalty_ff <= spare_valid_ff ? spare_penalty_ff : clamped;
         rsp_sat_ff     <= spare_valid_ff ? spare_sat_ff : sat_next;
      end
      if (load_spare) begin
         spare_penalty_ff <= clamped;
         spare_sat_ff     <= sat_next;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.penalty   = rsp_penalty_ff;
   assign rsp_bus.saturated = rsp_sat_ff;

   acc_within_limit: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= rgpc_pkg::PENALTY_LIMIT)
      else $error("penalty accumulator above limit");

   acc_cleared_after_result: assert property (@(posedge clock) disable iff (reset)
      load_result |=> (acc_ff == '0) && !acc_sat_ff)
      else $error("accumulator not cleared after a result");

   result_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_penalty_ff <= rgpc_pkg::PENALTY_LIMIT)
      else $error("result penalty above limit");

   spare_result_kept: assert property (@(posedge clock) disable iff (reset)
      (spare_valid_ff && ctl_in.valid && ctl_in.last) |-> !advance)
      else $error("pipeline moved over a full result buffer");

   spare_behind_head: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> rsp_valid_ff)
      else $error("spare result held with an empty head");

endmodule

// ===== hw/rtl/range_gap_penalty_counter_unit.sv =====
// top level of the range gap penalty counter
//
// Scores one ordering of a presence/absence matrix, one row per item on
// req_bus. Bit c of presence_row marks taxon column c present; only the
// low columns_in_use columns are scored (register 0 on the apb port,
// reset value 64). For each scored column the absences between its first
// and last presence are summed; last_row ends the ordering.
// On a last row one item leaves on rsp_bus with the penalty (clamped to
// 65536) and saturated, set when a gap counter held at 2047 or the penalty
// clamped. Rows not marked last give no result.
// A last row passes the per-column update, both adder tree levels and the
// accumulator, one stage each, before rsp_bus.valid rises. Throughput: one
// row per cycle unless the pipeline stalls.
// Reset clears all column state, the accumulator and the result valid flags.
// Two result registers sit on rsp_bus. While results wait, rows keep
// flowing; a last row that reaches the accumulator with both registers
// full stalls the pipeline, and req_bus.ready drops until one is taken.
`timescale 1ns / 1ps

module range_gap_penalty_counter_unit #(
   parameter int MAX_COLUMNS = rgpc_pkg::DEFAULT_MAX_COLUMNS
) (
   input  logic                                clock,
   input  logic                                reset,
   rgpc_req_if.sink                            req_bus,
   rgpc_rsp_if.source                          rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rgpc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rgpc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rgpc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic [rgpc_pkg::CFG_W-1:0] columns_in_use;
   logic                       advance;
   rgpc_pkg::ctl_type          bank_ctl;
   rgpc_pkg::ctl_type          tree_ctl;
   logic [rgpc_pkg::GAP_W-1:0] contrib [MAX_COLUMNS];
   logic [rgpc_pkg::PEN_W-1:0] row_sum;

   assign req_bus.ready = advance;

   rgpc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .columns_in_use (columns_in_use)
   );

   rgpc_column_bank #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_bank (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (req_bus.valid),
      .presence_row   (req_bus.presence_row),
      .last_row       (req_bus.last_row),
      .columns_in_use (columns_in_use),
      .ctl_out        (bank_ctl),
      .contrib        (contrib)
   );

   rgpc_sum_tree #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_tree (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ctl_in  (bank_ctl),
      .contrib (contrib),
      .ctl_out (tree_ctl),
      .row_sum (row_sum)
   );

   rgpc_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (tree_ctl),
      .row_sum (row_sum),
      .advance (advance),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the range gap penalty counter
`timescale 1ns / 1ps

module tb;

   localparam int          MAX_COLS     = rgpc_pkg::DEFAULT_MAX_COLUMNS;
   localparam int          SETTLE_COUNT = 8;
   localparam int          LIMIT_GAPS   = 1025;
   localparam int          RANDOM_ROWS  = 165;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam logic [rgpc_pkg::ROW_W-1:0] ALL_ONES  = {rgpc_pkg::ROW_W{1'b1}};
   localparam logic [rgpc_pkg::ROW_W-1:0] ALL_ZEROS = {rgpc_pkg::ROW_W{1'b0}};

   typedef struct packed {
      logic [rgpc_pkg::PEN_W-1:0] penalty;
      logic                       saturated;
   } score_type;

   logic                            clock;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [rgpc_pkg::CSR_ADDR_W-1:0] paddr;
   logic [rgpc_pkg::CSR_DATA_W-1:0] pwdata;
   logic [rgpc_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   rgpc_req_if req_bus ();
   rgpc_rsp_if rsp_bus ();

   range_gap_penalty_counter_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // scoring state of the predictor
   logic [rgpc_pkg::CFG_W-1:0] cols_cfg;
   bit                         col_seen [MAX_COLS];
   logic [rgpc_pkg::GAP_W-1:0] gap_run [MAX_COLS];
   logic [rgpc_pkg::PEN_W-1:0] pen_total;
   logic                       pen_sat;

   score_type   expected_scores [$];
   int          error_count = 0;
   int          src_idle_pct;
   int          snk_idle_pct;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_scores();
      for (int c = 0; c < MAX_COLS; c++) begin
         col_seen[c] = 1'b0;
         gap_run[c]  = '0;
      end
      pen_total = '0;
      pen_sat   = 1'b0;
   endfunction

   function automatic bit score_row(input logic [rgpc_pkg::ROW_W-1:0] row, input logic last,
                                    output score_type result);
      int unsigned                n;
      logic [rgpc_pkg::PEN_W:0]   sum;
      n = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
      for (int unsigned c = 0; c < n; c++) begin
         if (row[c]) begin
            if (col_seen[c]) begin
               sum = pen_total + gap_run[c];
               if (sum > rgpc_pkg::PENALTY_LIMIT) begin
                  sum     = {1'b0, rgpc_pkg::PENALTY_LIMIT};
                  pen_sat = 1'b1;
               end
               pen_total = sum[rgpc_pkg::PEN_W-1:0];
            end
            col_seen[c] = 1'b1;
            gap_run[c]  = '0;
         end else if (col_seen[c]) begin
            if (gap_run[c] == rgpc_pkg::GAP_LIMIT) begin
               pen_sat = 1'b1;
            end else begin
               gap_run[c] = gap_run[c] + 1'b1;
            end
         end
      end
      result = '0;
      if (!last) begin
         return 1'b0;
      end
      result.penalty   = pen_total;
      result.saturated = pen_sat;
      clear_scores();
      return 1'b1;
   endfunction

   task automatic send_row(input logic [rgpc_pkg::ROW_W-1:0] row, input logic last);
      score_type result;
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid        <= 1'b0;
         req_bus.presence_row <= {$urandom, $urandom};
         req_bus.last_row     <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.presence_row <= row;
      req_bus.last_row     <= last;
      do @(posedge clock); while (!req_bus.ready);
      if (score_row(row, last, result)) begin
         expected_scores = {expected_scores, result};
      end
   endtask

   // wait until the block has nothing left in flight
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_COUNT) @(posedge clock);
   endtask

   task automatic write_column_count(input logic [rgpc_pkg::CFG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= rgpc_pkg::CSR_ADDR_W'(4 * int'(rgpc_pkg::REG_COLUMNS_IN_USE));
      pwdata  <= {$urandom_range(1) ? $urandom : 32'd0} & ~32'h7f | 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      cols_cfg = value;
      // read back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[rgpc_pkg::CFG_W-1:0] !== value) begin
         $display("%t columns_in_use read back: expected %0d, actual %0d",
                  $time, value, prdata[rgpc_pkg::CFG_W-1:0]);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_single_orderings();
      send_row(ALL_ONES, 1'b1);
      send_row(ALL_ZEROS, 1'b1);
      send_row(ALL_ONES, 1'b0);
      send_row(ALL_ZEROS, 1'b0);
      send_row(ALL_ZEROS, 1'b0);
      send_row(ALL_ONES, 1'b1);
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_row(64'h5555_5555_5555_5555, 1'b0);
      send_row(ALL_ONES, 1'b1);
      // absences after the last presence are dropped
      send_row(ALL_ONES, 1'b0);
      send_row(ALL_ZEROS, 1'b0);
      send_row(ALL_ZEROS, 1'b1);
      send_row(64'h8000_0000_0000_0000, 1'b0);
      send_row(ALL_ZEROS, 1'b0);
      send_row(64'h8000_0000_0000_0001, 1'b1);
   endtask

   task automatic test_column_count();
      settle();
      write_column_count(7'd0);
      send_row(ALL_ONES, 1'b0);
      send_row(ALL_ZEROS, 1'b0);
      send_row(ALL_ONES, 1'b1);
      settle();
      write_column_count(7'd127);
      send_row(ALL_ONES, 1'b0);
      send_row(ALL_ZEROS, 1'b0);
      send_row(ALL_ONES, 1'b1);
      settle();
      write_column_count(7'd1);
      send_row(ALL_ONES, 1'b0);
      send_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      send_row(ALL_ONES, 1'b1);
      // column count changed in the middle of an ordering
      settle();
      write_column_count(7'd64);
      send_row(ALL_ONES, 1'b0);
      send_row(ALL_ZEROS, 1'b0);
      settle();
      write_column_count(7'd1);
      send_row(ALL_ZEROS, 1'b0);
      settle();
      write_column_count(7'd64);
      send_row(ALL_ONES, 1'b1);
   endtask

   task automatic test_penalty_limit();
      settle();
      write_column_count(7'd64);
      send_row(ALL_ONES, 1'b0);
      repeat (LIMIT_GAPS) send_row(ALL_ZEROS, 1'b0);
      send_row(ALL_ONES, 1'b1);
   endtask

   task automatic test_random_orderings(input int src_pct, input int snk_pct,
                                        input int row_count);
      int                         sent;
      int                         len;
      int                         mode;
      logic [rgpc_pkg::CFG_W-1:0] cols;
      logic [rgpc_pkg::ROW_W-1:0] keep_mask;
      logic [rgpc_pkg::ROW_W-1:0] row;
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      sent = 0;
      while (sent < row_count) begin
         if ($urandom_range(3) == 0) begin
            settle();
            case ($urandom_range(9))
               0:       cols = 7'd0;
               1:       cols = 7'd1;
               2:       cols = 7'd64;
               3:       cols = 7'd127;
               4:       cols = rgpc_pkg::CFG_W'($urandom_range(65, 127));
               default: cols = rgpc_pkg::CFG_W'($urandom_range(1, 64));
            endcase
            write_column_count(cols);
         end
         len  = ($urandom_range(19) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 20);
         mode = $urandom_range(4);
         keep_mask = $urandom_range(1) ? ALL_ONES : ({$urandom, $urandom} | {$urandom, $urandom});
         for (int r = 0; r < len; r++) begin
            case (mode)
               0:       row = {$urandom, $urandom};
               1:       row = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
               2:       row = {$urandom, $urandom} | {$urandom, $urandom};
               3:       row = $urandom_range(1) ? ALL_ONES : ALL_ZEROS;
               default: row = ($urandom_range(7) == 0) ? {$urandom, $urandom} : ALL_ZEROS;
            endcase
            send_row(row & keep_mask, r == len - 1);
            sent++;
         end
      end
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      score_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_scores.size() == 0) begin
            $display("%t unexpected item: penalty %0d saturated %0d",
                     $time, rsp_bus.penalty, rsp_bus.saturated);
            error_count++;
         end else begin
            want = expected_scores.pop_front();
            if (rsp_bus.penalty !== want.penalty) begin
               $display("%t penalty mismatch: expected %0d, actual %0d",
                        $time, want.penalty, rsp_bus.penalty);
               error_count++;
            end
            if (rsp_bus.saturated !== want.saturated) begin
               $display("%t saturated mismatch: expected %0d, actual %0d",
                        $time, want.saturated, rsp_bus.saturated);
               error_count++;
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%t timeout with %0d items outstanding", $time, expected_scores.size());
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.presence_row <= '0;
      req_bus.last_row     <= 1'b0;
      src_idle_pct = 8;
      snk_idle_pct = 47;
      cols_cfg     = rgpc_pkg::COLUMNS_RESET;
      clear_scores();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_orderings();
      test_column_count();
      test_penalty_limit();
      test_random_orderings(8, 47, RANDOM_ROWS);
      test_random_orderings(47, 8, RANDOM_ROWS);
      test_random_orderings(0, 0, RANDOM_ROWS);
      settle();

      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rgpc_pkg.sv
hw/rtl/rgpc_req_if.sv
hw/rtl/rgpc_rsp_if.sv
hw/rtl/rgpc_csr.sv
hw/rtl/rgpc_column_bank.sv
hw/rtl/rgpc_sum_tree.sv
hw/rtl/rgpc_accum.sv
hw/rtl/range_gap_penalty_counter_unit.sv
test/tb.sv
